### rtl/sscp_pkg.sv
// package for the segment-segment closest points pipeline
package sscp_pkg;

	localparam int CoordW = 24;
	localparam int ParamW = 17;
	localparam int DistW = 50;
	localparam int DiffW = 25;
	localparam int DotW = 52;
	localparam int WideW = 106;
	localparam int QBits = 16;
	localparam int LimW = 24;
	localparam logic [LimW-1:0] LimReset = LimW'(1);
	localparam logic [ParamW-1:0] OneQ16 = ParamW'(65536);

	typedef struct packed {
		logic signed [CoordW-1:0] a_start_x;
		logic signed [CoordW-1:0] a_start_y;
		logic signed [CoordW-1:0] a_start_z;
		logic signed [CoordW-1:0] a_end_x;
		logic signed [CoordW-1:0] a_end_y;
		logic signed [CoordW-1:0] a_end_z;
		logic signed [CoordW-1:0] b_start_x;
		logic signed [CoordW-1:0] b_start_y;
		logic signed [CoordW-1:0] b_start_z;
		logic signed [CoordW-1:0] b_end_x;
		logic signed [CoordW-1:0] b_end_y;
		logic signed [CoordW-1:0] b_end_z;
	} seg_pair_t;

	typedef struct packed {
		logic [DistW-1:0] dist_squared;
		logic [ParamW-1:0] param_a;
		logic [ParamW-1:0] param_b;
		logic signed [CoordW-1:0] near_a_x;
		logic signed [CoordW-1:0] near_a_y;
		logic signed [CoordW-1:0] near_a_z;
		logic signed [CoordW-1:0] near_b_x;
		logic signed [CoordW-1:0] near_b_y;
		logic signed [CoordW-1:0] near_b_z;
	} closest_t;

endpackage

### rtl/sscp_div.sv
// pipelined restoring divider, n/d clamped to [0,1] in q1.16, with sideband
module sscp_div #(
	parameter int NumW = sscp_pkg::WideW,
	parameter int SideW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [NumW-1:0] num,
	input  logic signed [NumW-1:0] den,
	input  logic [SideW-1:0] side_in,
	output logic out_valid,
	output logic [sscp_pkg::ParamW-1:0] quo,
	output logic [SideW-1:0] side_out
);
	import sscp_pkg::*;

	localparam int Steps = QBits;
	localparam logic [1:0] KindZero = 2'd0;
	localparam logic [1:0] KindOne = 2'd1;
	localparam logic [1:0] KindFrac = 2'd2;

	logic [Steps:0] vld_q;
	logic [NumW:0] rem_q [Steps+1];
	logic [NumW-1:0] dv_q [Steps+1];
	logic [QBits-1:0] q_q [Steps+1];
	logic [1:0] kind_q [Steps+1];
	logic [SideW-1:0] sd_q [Steps+1];

	logic [1:0] kind0;
	always_comb begin
		if (den <= 0 || num <= 0) kind0 = KindZero;
		else if (num >= den) kind0 = KindOne;
		else kind0 = KindFrac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Steps-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= {1'b0, num};
		dv_q[0] <= den;
		q_q[0] <= '0;
		kind_q[0] <= kind0;
		sd_q[0] <= side_in;
	end

	for (genvar g = 0; g < Steps; g++) begin : g_step
		logic [NumW:0] sh;
		logic ge;
		assign sh = {rem_q[g][NumW-1:0], 1'b0};
		assign ge = sh >= {1'b0, dv_q[g]};
		always_ff @(posedge clk) begin
			rem_q[g+1] <= ge ? sh - {1'b0, dv_q[g]} : sh;
			dv_q[g+1] <= dv_q[g];
			q_q[g+1] <= {q_q[g][QBits-2:0], ge};
			kind_q[g+1] <= kind_q[g];
			sd_q[g+1] <= sd_q[g];
		end
	end

	assign out_valid = vld_q[Steps];
	assign side_out = sd_q[Steps];
	always_comb begin
		unique case (kind_q[Steps])
			KindOne: quo = OneQ16;
			KindFrac: quo = {1'b0, q_q[Steps]};
			default: quo = '0;
		endcase
	end
endmodule

### rtl/segment_segment_closest_points.sv
// top level of the segment-segment closest points pipeline
// A fully pipelined datapath: one segment pair may be started in every cycle
// and busy stays low; each result, which passes through two chained 17-stage
// divider pipelines, appears for one cycle
// with done high. The receiver cannot stall. cfg_ready is always high.
module segment_segment_closest_points (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sscp_pkg::seg_pair_t pair,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [sscp_pkg::LimW-1:0] cfg_data,
	output logic done,
	output sscp_pkg::closest_t result
);
	import sscp_pkg::*;

	typedef logic signed [DiffW-1:0] d_t;
	typedef logic signed [DotW-1:0] dot_t;
	typedef logic signed [WideW-1:0] w_t;

	typedef struct packed {
		logic signed [CoordW-1:0] a1x, a1y, a1z, b1x, b1y, b1z;
		d_t dax, day, daz, dbx, dby, dbz;
	} geo_t;

	typedef struct packed {
		geo_t g;
		dot_t aa, bb, ab, ar, br;
	} dots_t;

	logic [LimW-1:0] lim_q;
	assign cfg_ready = 1'b1;
	assign busy = 1'b0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lim_q <= LimReset;
		else if (cfg_valid) lim_q <= cfg_data;
	end

	// s1: differences
	logic v_s1;
	geo_t g_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		g_s1.a1x <= pair.a_start_x; g_s1.a1y <= pair.a_start_y; g_s1.a1z <= pair.a_start_z;
		g_s1.b1x <= pair.b_start_x; g_s1.b1y <= pair.b_start_y; g_s1.b1z <= pair.b_start_z;
		g_s1.dax <= DiffW'(pair.a_end_x) - DiffW'(pair.a_start_x);
		g_s1.day <= DiffW'(pair.a_end_y) - DiffW'(pair.a_start_y);
		g_s1.daz <= DiffW'(pair.a_end_z) - DiffW'(pair.a_start_z);
		g_s1.dbx <= DiffW'(pair.b_end_x) - DiffW'(pair.b_start_x);
		g_s1.dby <= DiffW'(pair.b_end_y) - DiffW'(pair.b_start_y);
		g_s1.dbz <= DiffW'(pair.b_end_z) - DiffW'(pair.b_start_z);
	end

	// s2: products, s3: dot sums
	d_t rx, ry, rz;
	assign rx = DiffW'(g_s1.a1x) - DiffW'(g_s1.b1x);
	assign ry = DiffW'(g_s1.a1y) - DiffW'(g_s1.b1y);
	assign rz = DiffW'(g_s1.a1z) - DiffW'(g_s1.b1z);
	logic v_s2;
	geo_t g_s2;
	dot_t p_s2 [15];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		g_s2 <= g_s1;
		p_s2[0] <= DotW'(g_s1.dax) * DotW'(g_s1.dax);
		p_s2[1] <= DotW'(g_s1.day) * DotW'(g_s1.day);
		p_s2[2] <= DotW'(g_s1.daz) * DotW'(g_s1.daz);
		p_s2[3] <= DotW'(g_s1.dbx) * DotW'(g_s1.dbx);
		p_s2[4] <= DotW'(g_s1.dby) * DotW'(g_s1.dby);
		p_s2[5] <= DotW'(g_s1.dbz) * DotW'(g_s1.dbz);
		p_s2[6] <= DotW'(g_s1.dax) * DotW'(g_s1.dbx);
		p_s2[7] <= DotW'(g_s1.day) * DotW'(g_s1.dby);
		p_s2[8] <= DotW'(g_s1.daz) * DotW'(g_s1.dbz);
		p_s2[9] <= DotW'(g_s1.dax) * DotW'(rx);
		p_s2[10] <= DotW'(g_s1.day) * DotW'(ry);
		p_s2[11] <= DotW'(g_s1.daz) * DotW'(rz);
		p_s2[12] <= DotW'(g_s1.dbx) * DotW'(rx);
		p_s2[13] <= DotW'(g_s1.dby) * DotW'(ry);
		p_s2[14] <= DotW'(g_s1.dbz) * DotW'(rz);
	end
	logic v_s3;
	dots_t d_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		d_s3.g <= g_s2;
		d_s3.aa <= p_s2[0] + p_s2[1] + p_s2[2];
		d_s3.bb <= p_s2[3] + p_s2[4] + p_s2[5];
		d_s3.ab <= p_s2[6] + p_s2[7] + p_s2[8];
		d_s3.ar <= p_s2[9] + p_s2[10] + p_s2[11];
		d_s3.br <= p_s2[12] + p_s2[13] + p_s2[14];
	end

	// s4: cross products (each split in 4 partial products), s5: sum
	localparam int Half = DotW / 2;
	localparam int HalfW = Half + 1;
	localparam int PpW = 2 * Half + 2;
	typedef struct packed {
		logic signed [PpW-1:0] hh, hl, lh, ll;
	} pp_t;
	function automatic pp_t pmul(input dot_t x, input dot_t y);
		logic signed [HalfW-1:0] xh, xl, yh, yl;
		pp_t p;
		xh = HalfW'($signed(x[DotW-1:Half]));
		xl = {1'b0, x[Half-1:0]};
		yh = HalfW'($signed(y[DotW-1:Half]));
		yl = {1'b0, y[Half-1:0]};
		p.hh = PpW'(xh) * PpW'(yh);
		p.hl = PpW'(xh) * PpW'(yl);
		p.lh = PpW'(xl) * PpW'(yh);
		p.ll = PpW'(xl) * PpW'(yl);
		return p;
	endfunction
	function automatic w_t pjoin(input pp_t p);
		return (WideW'(p.hh) <<< (2 * Half)) + (WideW'(p.hl) <<< Half)
			+ (WideW'(p.lh) <<< Half) + WideW'(p.ll);
	endfunction
	logic v_s4, v_s5;
	dots_t d_s4, d_s5;
	pp_t m_s4 [6];
	w_t den_s5, ns_s5, nt_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		d_s4 <= d_s3;
		m_s4[0] <= pmul(d_s3.aa, d_s3.bb);
		m_s4[1] <= pmul(d_s3.ab, d_s3.ab);
		m_s4[2] <= pmul(d_s3.ab, d_s3.br);
		m_s4[3] <= pmul(d_s3.ar, d_s3.bb);
		m_s4[4] <= pmul(d_s3.aa, d_s3.br);
		m_s4[5] <= pmul(d_s3.ab, d_s3.ar);
		d_s5 <= d_s4;
		den_s5 <= pjoin(m_s4[0]) - pjoin(m_s4[1]);
		ns_s5 <= pjoin(m_s4[2]) - pjoin(m_s4[3]);
		nt_s5 <= pjoin(m_s4[4]) - pjoin(m_s4[5]);
	end

	// s6: case decision; first division
	typedef enum logic [2:0] {
		M_ZERO, M_T_ONLY, M_S_ONLY, M_SFIRST, M_TFIRST, M_BOTH
	} mode_t;

	typedef struct packed {
		dots_t d;
		mode_t mode;
		logic [ParamW-1:0] pre;
		logic pre_is_s;
		logic redo;
		w_t den;
		w_t nt;
	} ctl_t;

	logic apt, bpt;
	assign apt = d_s5.aa < DotW'(lim_q);
	assign bpt = d_s5.bb < DotW'(lim_q);
	ctl_t c0;
	w_t n0, dd0;
	always_comb begin
		c0 = '0;
		c0.d = d_s5;
		c0.den = den_s5;
		c0.nt = nt_s5;
		n0 = '0;
		dd0 = '0;
		if (apt && bpt) c0.mode = M_ZERO;
		else if (apt) begin
			c0.mode = M_T_ONLY;
			n0 = WideW'(d_s5.br); dd0 = WideW'(d_s5.bb);
		end else if (bpt) begin
			c0.mode = M_S_ONLY;
			n0 = -WideW'(d_s5.ar); dd0 = WideW'(d_s5.aa);
		end else if (d_s5.aa == 0 || d_s5.bb == 0) c0.mode = M_ZERO;
		else if (den_s5 <= 0 || ns_s5 < 0 || ns_s5 > den_s5) begin
			c0.mode = M_SFIRST;
			c0.pre_is_s = 1'b1;
			c0.pre = (den_s5 > 0 && ns_s5 > den_s5) ? OneQ16 : '0;
			n0 = WideW'(((den_s5 > 0 && ns_s5 > den_s5) ? d_s5.ab : dot_t'(0)) + d_s5.br);
			dd0 = WideW'(d_s5.bb);
			c0.redo = (n0 < 0) || (n0 > dd0);
		end else if (nt_s5 < 0 || nt_s5 > den_s5) begin
			c0.mode = M_TFIRST;
			c0.pre = (nt_s5 < 0) ? '0 : OneQ16;
			n0 = WideW'(((nt_s5 < 0) ? dot_t'(0) : d_s5.ab) - d_s5.ar);
			dd0 = WideW'(d_s5.aa);
			c0.redo = (n0 < 0) || (n0 > dd0);
		end else begin
			c0.mode = M_BOTH;
			n0 = ns_s5; dd0 = den_s5;
		end
	end

	logic v_s6;
	ctl_t c_s6;
	w_t n_s6, dd_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		c_s6 <= c0;
		n_s6 <= n0;
		dd_s6 <= dd0;
	end

	logic v1;
	logic [ParamW-1:0] q1;
	ctl_t c1;
	sscp_div #(.NumW(WideW), .SideW($bits(ctl_t))) u_div1 (
		.clk, .arst_n, .in_valid(v_s6), .num(n_s6), .den(dd_s6),
		.side_in(c_s6), .out_valid(v1), .quo(q1), .side_out(c1)
	);

	// second division
	typedef struct packed {
		ctl_t c;
		logic [ParamW-1:0] q1;
	} ctl2_t;
	ctl2_t k2;
	w_t n2, dd2;
	always_comb begin
		k2.c = c1;
		k2.q1 = q1;
		n2 = '0;
		dd2 = '0;
		unique case (c1.mode)
			M_SFIRST: begin
				n2 = WideW'(((q1 != '0) ? c1.d.ab : dot_t'(0)) - c1.d.ar);
				dd2 = WideW'(c1.d.aa);
			end
			M_TFIRST: begin
				n2 = WideW'(((q1 != '0) ? c1.d.ab : dot_t'(0)) + c1.d.br);
				dd2 = WideW'(c1.d.bb);
			end
			M_BOTH: begin
				n2 = c1.nt; dd2 = c1.den;
			end
			default: ;
		endcase
	end
	logic v_s7;
	ctl2_t k_s7;
	w_t n_s7, dd_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v1;
	end
	always_ff @(posedge clk) begin
		k_s7 <= k2;
		n_s7 <= n2;
		dd_s7 <= dd2;
	end
	logic v2;
	logic [ParamW-1:0] q2;
	ctl2_t k2o;
	sscp_div #(.NumW(WideW), .SideW($bits(ctl2_t))) u_div2 (
		.clk, .arst_n, .in_valid(v_s7), .num(n_s7), .den(dd_s7),
		.side_in(k_s7), .out_valid(v2), .quo(q2), .side_out(k2o)
	);

	// resolve s and t
	logic [ParamW-1:0] s_f, t_f;
	always_comb begin
		s_f = '0;
		t_f = '0;
		unique case (k2o.c.mode)
			M_T_ONLY: t_f = k2o.q1;
			M_S_ONLY: s_f = k2o.q1;
			M_SFIRST: begin
				t_f = k2o.q1;
				s_f = k2o.c.redo ? q2 : k2o.c.pre;
			end
			M_TFIRST: begin
				s_f = k2o.q1;
				t_f = k2o.c.redo ? q2 : k2o.c.pre;
			end
			M_BOTH: begin
				s_f = k2o.q1; t_f = q2;
			end
			default: ;
		endcase
	end

	// points: s8 products, s9 rounding, s10 deltas squared, s11 sum
	localparam int PW = DiffW + ParamW + 1;
	logic v_s8, v_s9, v_s10, v_s11;
	geo_t g_s8;
	logic [ParamW-1:0] s_s8, t_s8;
	logic signed [PW-1:0] pa_s8 [3], pb_s8 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
		end else begin
			v_s8 <= v2; v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10;
		end
	end
	always_ff @(posedge clk) begin
		g_s8 <= k2o.c.d.g;
		s_s8 <= s_f;
		t_s8 <= t_f;
		pa_s8[0] <= PW'(k2o.c.d.g.dax) * PW'({1'b0, s_f});
		pa_s8[1] <= PW'(k2o.c.d.g.day) * PW'({1'b0, s_f});
		pa_s8[2] <= PW'(k2o.c.d.g.daz) * PW'({1'b0, s_f});
		pb_s8[0] <= PW'(k2o.c.d.g.dbx) * PW'({1'b0, t_f});
		pb_s8[1] <= PW'(k2o.c.d.g.dby) * PW'({1'b0, t_f});
		pb_s8[2] <= PW'(k2o.c.d.g.dbz) * PW'({1'b0, t_f});
	end
	function automatic d_t rnd(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] x;
		x = v + PW'(32768);
		return DiffW'(x >>> QBits);
	endfunction
	logic signed [CoordW-1:0] na_s9 [3], nb_s9 [3];
	logic [ParamW-1:0] s_s9, t_s9, s_s10, t_s10;
	always_ff @(posedge clk) begin
		s_s9 <= s_s8; t_s9 <= t_s8;
		na_s9[0] <= CoordW'(DiffW'(g_s8.a1x) + rnd(pa_s8[0]));
		na_s9[1] <= CoordW'(DiffW'(g_s8.a1y) + rnd(pa_s8[1]));
		na_s9[2] <= CoordW'(DiffW'(g_s8.a1z) + rnd(pa_s8[2]));
		nb_s9[0] <= CoordW'(DiffW'(g_s8.b1x) + rnd(pb_s8[0]));
		nb_s9[1] <= CoordW'(DiffW'(g_s8.b1y) + rnd(pb_s8[1]));
		nb_s9[2] <= CoordW'(DiffW'(g_s8.b1z) + rnd(pb_s8[2]));
	end
	logic signed [CoordW-1:0] na_s10 [3], nb_s10 [3], na_s11 [3], nb_s11 [3];
	logic [DistW-1:0] sq_s10 [3];
	logic [DistW-1:0] dist_s11;
	logic [ParamW-1:0] s_s11, t_s11;
	for (genvar i = 0; i < 3; i++) begin : g_sq
		d_t df;
		assign df = DiffW'(na_s9[i]) - DiffW'(nb_s9[i]);
		always_ff @(posedge clk) begin
			sq_s10[i] <= DistW'(DistW'(df) * DistW'(df));
			na_s10[i] <= na_s9[i];
			nb_s10[i] <= nb_s9[i];
			na_s11[i] <= na_s10[i];
			nb_s11[i] <= nb_s10[i];
		end
	end
	always_ff @(posedge clk) begin
		s_s10 <= s_s9; t_s10 <= t_s9;
		s_s11 <= s_s10; t_s11 <= t_s10;
		dist_s11 <= sq_s10[0] + sq_s10[1] + sq_s10[2];
	end

	assign done = v_s11;
	always_comb begin
		result.dist_squared = dist_s11;
		result.param_a = s_s11;
		result.param_b = t_s11;
		result.near_a_x = na_s11[0];
		result.near_a_y = na_s11[1];
		result.near_a_z = na_s11[2];
		result.near_b_x = nb_s11[0];
		result.near_b_y = nb_s11[1];
		result.near_b_z = nb_s11[2];
	end

	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.param_a <= OneQ16 && result.param_b <= OneQ16))
		else $error("parameter out of range");
	a_zero_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(v2 && k2o.c.mode == M_ZERO) |=> (s_s8 == '0 && t_s8 == '0))
		else $error("zero case gave nonzero parameter");
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> $past(v_s5))
		else $error("valid lost in pipeline");
endmodule
